// File: hw/rtl/ffcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffcp_pkg
// shared constants, types and the acknowledge byte table of the frame parser
// ----------------------------------------------------------------------------
package ffcp_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int SUM_BYTES   = 6;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int POS_W       = 4;

    localparam logic [7:0] HDR0     = 8'h6B;
    localparam logic [7:0] HDR1     = 8'h79;
    localparam logic [7:0] ACK_HDR1 = 8'h6A;
    localparam logic [7:0] MSG_TYPE = 8'h81;
    localparam logic [7:0] ACK_TYPE = 8'h82;
    localparam logic [7:0] TAIL     = 8'hFB;

    // byte positions inside a frame
    localparam logic [IDX_W-1:0] POS_HDR0 = IDX_W'(0);
    localparam logic [IDX_W-1:0] POS_HDR1 = IDX_W'(1);
    localparam logic [IDX_W-1:0] POS_TYPE = IDX_W'(3);
    localparam logic [IDX_W-1:0] POS_CMD  = IDX_W'(4);
    localparam logic [IDX_W-1:0] POS_SUM  = IDX_W'(6);
    localparam logic [IDX_W-1:0] POS_TAIL = IDX_W'(7);

    typedef enum logic [1:0] {
        EV_ACK      = 2'd0,
        EV_BAD_TAIL = 2'd1,
        EV_BAD_TYPE = 2'd2,
        EV_BAD_SUM  = 2'd3
    } t_event;

    // acknowledge frame: 6B 6A 00 82 cmd 00 sum FB
    function automatic logic [7:0] ack_byte(input logic [IDX_W-1:0] idx,
                                            input logic [7:0]       cmd,
                                            input logic [7:0]       sum);
        logic [7:0] v;
        v = 8'h00;
        case (idx)
            POS_HDR0: v = HDR0;
            POS_HDR1: v = ACK_HDR1;
            POS_TYPE: v = ACK_TYPE;
            POS_CMD:  v = cmd;
            POS_SUM:  v = sum;
            POS_TAIL: v = TAIL;
            default:  v = 8'h00;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/fixed_frame_command_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_frame_command_parser_top
// 8-byte command frame parser with sum checksum and acknowledge generator
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_ready) carries one received byte per
//   transaction. header bytes and middle bytes of a frame cause no result.
//   output channel (o_out_valid / i_out_ready) carries results: one error
//   result for a rejected frame, or eight acknowledge bytes for a good one.
//   o_run_end marks the last result caused by one input byte.
// sequence
//   bytes that do not end a frame leave o_in_ready high. the final byte of a
//   frame starts a sum pass over bytes 0 to 5 through the shared 8-bit adder,
//   then a check state that registers the first result. acknowledge bytes
//   leave one per cycle while i_out_ready is high, the same adder building the
//   ack checksum as bytes go out. o_in_ready is low from the final byte until
//   the last result is taken.
// reset
//   synchronous, active low: hunting for a header, counters and last command
//   cleared, no result pending. frame bytes are not cleared.
// stall
//   a result holds on the outputs until i_out_ready; input stays blocked.
//   counters and last command are steady while results are delivered.
// ----------------------------------------------------------------------------
module fixed_frame_command_parser_top
    import ffcp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_event_res,
    output logic [7:0]       o_tx_byte,
    output logic [7:0]       o_command_code,
    output logic             o_run_end,
    output logic [7:0]       o_last_command,
    output logic [31:0]      o_good_frame_count,
    output logic [31:0]      o_tail_error_count,
    output logic [31:0]      o_type_error_count,
    output logic [31:0]      o_sum_error_count
);

    // sequencer states
    typedef enum logic [3:0] {
        ST_RECV  = 4'b0001,
        ST_SUM   = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_SEND  = 4'b1000
    } t_state;

    // frame hunting phase
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_HEAD1 = 3'b010,
        PH_DATA  = 3'b100
    } t_phase;

    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [7:0]         r_frame [FRAME_BYTES];
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [7:0]         r_acc, n_acc;
    logic [7:0]         r_recent, n_recent;
    logic [31:0]        r_good, n_good;
    logic [31:0]        r_tail_err, n_tail_err;
    logic [31:0]        r_type_err, n_type_err;
    logic [31:0]        r_sum_err, n_sum_err;
    logic               r_out_valid, n_out_valid;
    t_event             r_event, n_event;
    logic [7:0]         r_tx, n_tx;
    logic [7:0]         r_cmd, n_cmd;
    logic               r_run_end, n_run_end;

    logic               w_in_fire;
    logic               w_out_fire;
    logic               w_frame_we;
    logic [IDX_W-1:0]   w_frame_wa;
    logic [7:0]         w_addend;
    logic [7:0]         w_sum;
    logic [POS_W-1:0]   w_pos_inc;
    logic [IDX_W-1:0]   w_idx_inc;

    assign o_in_ready = (r_state == ST_RECV);
    assign w_in_fire  = i_in_valid & o_in_ready;
    assign w_out_fire = r_out_valid & i_out_ready;
    assign w_pos_inc  = r_pos + POS_W'(1);
    assign w_idx_inc  = r_idx + IDX_W'(1);

    // shared adder: frame sum during the sum pass, ack sum while sending
    assign w_addend = (r_state == ST_SUM) ? r_frame[r_idx] : r_tx;
    assign w_sum    = r_acc + w_addend;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_recent    = r_recent;
        n_good      = r_good;
        n_tail_err  = r_tail_err;
        n_type_err  = r_type_err;
        n_sum_err   = r_sum_err;
        n_out_valid = r_out_valid;
        n_event     = r_event;
        n_tx        = r_tx;
        n_cmd       = r_cmd;
        n_run_end   = r_run_end;
        w_frame_we  = 1'b0;
        w_frame_wa  = r_pos[IDX_W-1:0];

        case (r_state)
            ST_RECV: begin
                if (w_in_fire) begin
                    case (r_phase)
                        PH_IDLE: begin
                            if (i_rx_byte == HDR0) begin
                                w_frame_we = 1'b1;
                                w_frame_wa = POS_HDR0;
                                n_pos      = POS_W'(1);
                                n_phase    = PH_HEAD1;
                            end
                        end
                        PH_HEAD1: begin
                            // a wrong second byte is dropped, not re-tested
                            if (i_rx_byte == HDR1) begin
                                w_frame_we = 1'b1;
                                w_frame_wa = POS_HDR1;
                                n_pos      = POS_W'(2);
                                n_phase    = PH_DATA;
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end
                        PH_DATA: begin
                            w_frame_we = 1'b1;
                            n_pos      = w_pos_inc;
                            if (w_pos_inc >= POS_W'(FRAME_BYTES)) begin
                                n_phase = PH_IDLE;
                                n_state = ST_SUM;
                                n_idx   = '0;
                                n_acc   = 8'h00;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
            ST_SUM: begin
                n_acc = w_sum;
                n_idx = w_idx_inc;
                if (r_idx == IDX_W'(SUM_BYTES - 1)) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_out_valid = 1'b1;
                n_run_end   = 1'b1;
                n_tx        = 8'h00;
                n_cmd       = 8'h00;
                n_state     = ST_SEND;
                // first failing check in tail, type, sum order wins
                if (r_frame[POS_TAIL] != TAIL) begin
                    n_event    = EV_BAD_TAIL;
                    n_tail_err = r_tail_err + 32'd1;
                end else if (r_frame[POS_TYPE] != MSG_TYPE) begin
                    n_event    = EV_BAD_TYPE;
                    n_type_err = r_type_err + 32'd1;
                end else if (r_acc != r_frame[POS_SUM]) begin
                    n_event   = EV_BAD_SUM;
                    n_sum_err = r_sum_err + 32'd1;
                end else begin
                    n_event   = EV_ACK;
                    n_good    = r_good + 32'd1;
                    n_recent  = r_frame[POS_CMD];
                    n_cmd     = r_frame[POS_CMD];
                    n_tx      = ack_byte(POS_HDR0, r_frame[POS_CMD], 8'h00);
                    n_run_end = 1'b0;
                    n_idx     = '0;
                    n_acc     = 8'h00;
                end
            end
            ST_SEND: begin
                if (w_out_fire) begin
                    if (r_run_end) begin
                        n_out_valid = 1'b0;
                        n_state     = ST_RECV;
                    end else begin
                        // after byte five the adder holds the ack checksum
                        n_acc     = w_sum;
                        n_idx     = w_idx_inc;
                        n_tx      = ack_byte(w_idx_inc, r_cmd, w_sum);
                        n_run_end = (w_idx_inc == POS_TAIL);
                    end
                end
            end
            default: begin
                n_state     = ST_RECV;
                n_out_valid = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RECV;
            r_phase     <= PH_IDLE;
            r_pos       <= '0;
            r_recent    <= 8'h00;
            r_good      <= 32'd0;
            r_tail_err  <= 32'd0;
            r_type_err  <= 32'd0;
            r_sum_err   <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_recent    <= n_recent;
            r_good      <= n_good;
            r_tail_err  <= n_tail_err;
            r_type_err  <= n_type_err;
            r_sum_err   <= n_sum_err;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath and result payload
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_acc     <= n_acc;
        r_event   <= n_event;
        r_tx      <= n_tx;
        r_cmd     <= n_cmd;
        r_run_end <= n_run_end;
    end

    // frame bytes
    always_ff @(posedge i_clk) begin
        if (w_frame_we) begin
            r_frame[w_frame_wa] <= i_rx_byte;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_event_res        = r_event;
    assign o_tx_byte          = r_tx;
    assign o_command_code     = r_cmd;
    assign o_run_end          = r_run_end;
    assign o_last_command     = r_recent;
    assign o_good_frame_count = r_good;
    assign o_tail_error_count = r_tail_err;
    assign o_type_error_count = r_type_err;
    assign o_sum_error_count  = r_sum_err;

endmodule
`default_nettype wire

// File: hw/rtl/ffcp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffcp_checker
// port-level checks on the frame parser, bound to the top level
// ----------------------------------------------------------------------------
module ffcp_checker
    import ffcp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  o_event_res,
    input wire logic [7:0]  o_tx_byte,
    input wire logic [7:0]  o_command_code,
    input wire logic        o_run_end,
    input wire logic [7:0]  o_last_command
);

    // input is blocked while any result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_tx_byte) && $stable(o_event_res)
             && $stable(o_run_end)))
        else $error("stalled result changed");

    // an error result is a single final transaction with empty payload
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_res != EV_ACK)) |->
            (o_run_end && (o_tx_byte == 8'h00) && (o_command_code == 8'h00)))
        else $error("malformed error result");

    // last acknowledge byte is the tail and carries the recorded command
    a_ack_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_run_end && (o_event_res == EV_ACK)) |->
            ((o_tx_byte == TAIL) && (o_command_code == o_last_command)))
        else $error("acknowledge frame ends badly");

endmodule

bind fixed_frame_command_parser_top ffcp_checker u_ffcp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_event_res    (o_event_res),
    .o_tx_byte      (o_tx_byte),
    .o_command_code (o_command_code),
    .o_run_end      (o_run_end),
    .o_last_command (o_last_command)
);
`default_nettype wire
